[rtl/fur_pkg.sv]
// Shared types and constants for the file upload receiver.
// No dependencies; imported by file_upload_receiver, upload_checker and testbench.
`timescale 1ns / 1ps
`default_nettype none

package fur_pkg;

	localparam int ADDR_W            = 16;
	localparam int PTR_W             = 17;
	localparam int SLOT_W            = 4;
	localparam int BYTE_W            = 8;
	localparam int SLOTS_DEF         = 10;
	localparam int SEGMENT_BYTES_DEF = 512;
	localparam int CFG_IDX_W         = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

	// reply codes
	localparam logic [1:0] REPLY_NONE  = 2'd0;
	localparam logic [1:0] REPLY_ACK   = 2'd1;
	localparam logic [1:0] REPLY_NACK  = 2'd2;
	localparam logic [1:0] REPLY_ERROR = 2'd3;

	// item opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_DATA   = 3'd3,
		PH_CHK    = 3'd4
	} phase_t;

	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] rx_byte;
		logic [SLOT_W-1:0] slot_number;
		logic              file_kind;
	} item_t;

	typedef struct packed {
		logic [1:0]        reply_code;
		logic              write_en;
		logic [ADDR_W-1:0] write_addr;
		logic [BYTE_W-1:0] write_data;
		logic              erase_en;
		logic [ADDR_W-1:0] erase_addr;
		logic              commit_en;
		logic [SLOT_W-1:0] file_count;
		logic [PTR_W-1:0]  next_free_addr;
	} result_t;

	typedef struct packed {
		logic              in_use;
		logic              kind;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
	} slot_entry_t;

endpackage

`default_nettype wire

[rtl/fur_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fur_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/file_upload_receiver.sv]
// File upload receiver: top level, sequencing and slot table.
// Depends on fur_pkg and fur_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - item channel (item_valid/item_ready/item): a start item (op 0) names the
//   slot and file kind; byte items (op 1) then carry length low, length high,
//   the data bytes and one checksum byte.
// - result channel (result_valid/result_ready/result): exactly one result item
//   per accepted item, in order: flash write, segment erase, reply code,
//   commit flag, slot count and next free address.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): region_start and
//   region_end; always ready. Write only while no item is in flight.
// Results are registered: each appears in the cycle after its item is accepted.
// Throughput: one item per cycle while the output register is empty or draining.
//   The per-item work (compare, add, segment alignment check) is combinational;
//   the slot table RAM is read ahead at the pending slot, which a start item sets
//   at least three items before the checksum byte that needs it.
// Stall: a single output register holds the result; item_ready stays high
//   while that register is empty or being drained this cycle, so a stalled
//   receiver stops intake after one buffered result.
// Reset: the receiver goes idle, no slot is in use (per-entry valid bits),
//   free pointer = region_start = 0, region_end = 0xFFFF. No clearing pass.
module file_upload_receiver #(
	parameter int SLOTS         = fur_pkg::SLOTS_DEF,
	parameter int SEGMENT_BYTES = fur_pkg::SEGMENT_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire fur_pkg::item_t                    item,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output fur_pkg::result_t                       result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fur_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fur_pkg::ADDR_W-1:0]        cfg_data
);

	import fur_pkg::*;

	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Segment alignment: SEGMENT_BYTES = 2^SEG_TZ * SEG_ODD. An address is
	// aligned when its low SEG_TZ bits are zero and the rest is a multiple
	// of SEG_ODD, tested by multiplying with the modular inverse.
	function automatic int seg_tz(input int v);
		int n;
		n = 0;
		for (int i = 0; i < 13; i++) begin
			if (((v >> i) & 1) == 0 && n == i) begin
				n = i + 1;
			end
		end
		return n;
	endfunction

	function automatic logic [PTR_W-1:0] odd_inverse(input int m);
		logic [PTR_W-1:0] x;
		logic [PTR_W-1:0] mm;
		mm = PTR_W'(m);
		x  = mm;
		for (int i = 0; i < 4; i++) begin
			x = PTR_W'(x * (PTR_W'(2) - PTR_W'(mm * x)));
		end
		return x;
	endfunction

	localparam int               SEG_TZ   = seg_tz(SEGMENT_BYTES);
	localparam int               SEG_ODD  = SEGMENT_BYTES >> SEG_TZ;
	localparam logic [PTR_W-1:0] SEG_INV  = odd_inverse(SEG_ODD);
	localparam logic [PTR_W-1:0] SEG_LIM  = PTR_W'(((2 ** PTR_W) - 1) / SEG_ODD);
	localparam logic [PTR_W-1:0] SEG_MASK = PTR_W'((2 ** SEG_TZ) - 1);

	function automatic logic seg_aligned(input logic [PTR_W-1:0] a);
		logic [PTR_W-1:0] x;
		logic [PTR_W-1:0] p;
		x = a >> SEG_TZ;
		p = PTR_W'(x * SEG_INV);
		return ((a & SEG_MASK) == '0) && (p <= SEG_LIM);
	endfunction

	// control state
	phase_t            phase_q, phase_d;
	logic [ADDR_W-1:0] region_start_q, region_end_q;
	logic [PTR_W-1:0]  free_ptr_q, free_ptr_d;
	logic [SLOT_W-1:0] used_q, used_d;
	logic              slot_valid_q [SLOTS];
	logic              result_valid_q;
	result_t           result_q, result_d;

	// upload context (no reset needed, always set before use)
	logic [ADDR_W-1:0] length_q, length_d;
	logic [ADDR_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic              base_aligned_q, base_aligned_d;
	logic [PTR_W-1:0]  wp_q, wp_d;
	logic [SLOT_W-1:0] pslot_q, pslot_d;
	logic              pkind_q, pkind_d;

	// slot table
	logic              tbl_we;
	logic [SLOT_AW-1:0] tbl_idx;
	slot_entry_t       tbl_wdata, tbl_rdata;
	logic              slot_ok;
	logic              slot_in_use;

	logic              accept;
	logic [PTR_W-1:0]  wp_inc;
	logic [ADDR_W-1:0] count_inc;
	logic [BYTE_W-1:0] sum_data, sum_chk;
	logic [PTR_W-1:0]  new_free;
	logic [PTR_W-1:0]  end_ext;
	logic              fp_aligned, wp_inc_aligned;

	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// read ahead at the pending slot; entry in use needs both valid bit and RAM flag
	assign slot_ok     = (pslot_q != '0) && (pslot_q <= SLOT_W'(SLOTS));
	assign tbl_idx     = SLOT_AW'(pslot_q - SLOT_W'(1));
	assign slot_in_use = slot_ok && slot_valid_q[tbl_idx] && tbl_rdata.in_use;

	fur_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_idx),
		.wdata(tbl_wdata),
		.raddr(tbl_idx),
		.rdata(tbl_rdata)
	);

	assign wp_inc         = wp_q + PTR_W'(1);
	assign count_inc      = count_q + ADDR_W'(1);
	assign sum_data       = sum_q + item.rx_byte;
	assign sum_chk        = sum_q + item.rx_byte;
	assign new_free       = {1'b0, base_q} + {1'b0, count_q};
	assign end_ext        = {1'b0, region_end_q};
	assign fp_aligned     = seg_aligned(free_ptr_q);
	assign wp_inc_aligned = seg_aligned(wp_inc);

	always_comb begin
		phase_d        = phase_q;
		length_d       = length_q;
		count_d        = count_q;
		sum_d          = sum_q;
		base_d         = base_q;
		base_aligned_d = base_aligned_q;
		wp_d           = wp_q;
		pslot_d        = pslot_q;
		pkind_d        = pkind_q;
		free_ptr_d     = free_ptr_q;
		used_d         = used_q;
		tbl_we         = 1'b0;
		tbl_wdata      = '{in_use: 1'b1, kind: pkind_q, start: base_q, size: count_q};
		result_d       = '0;

		if (item.op == OP_START) begin
			pslot_d = item.slot_number;
			pkind_d = item.file_kind;
			phase_d = PH_LEN_LO;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_LEN_LO: begin
					sum_d    = '0;
					count_d  = '0;
					length_d = {{(ADDR_W-BYTE_W){1'b0}}, item.rx_byte};
					phase_d  = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					length_d = {item.rx_byte, length_q[BYTE_W-1:0]};
					if (free_ptr_q < {1'b0, region_start_q} || free_ptr_q > end_ext) begin
						result_d.reply_code = REPLY_ERROR;
						phase_d             = PH_IDLE;
					end else begin
						base_d         = free_ptr_q[ADDR_W-1:0];
						base_aligned_d = fp_aligned;
						wp_d           = free_ptr_q;
						if (fp_aligned) begin
							result_d.erase_en   = 1'b1;
							result_d.erase_addr = free_ptr_q[ADDR_W-1:0];
						end
						phase_d = (length_d == '0) ? PH_CHK : PH_DATA;
					end
				end
				PH_DATA: begin
					if (wp_q > end_ext) begin
						result_d.reply_code = REPLY_ERROR;
						phase_d             = PH_IDLE;
					end else begin
						result_d.write_en   = 1'b1;
						result_d.write_addr = wp_q[ADDR_W-1:0];
						result_d.write_data = item.rx_byte;
						wp_d                = wp_inc;
						count_d             = count_inc;
						sum_d               = sum_data;
						if (count_inc == length_q) begin
							phase_d = PH_CHK;
						end else if (wp_inc_aligned && wp_inc <= end_ext) begin
							result_d.erase_en   = 1'b1;
							result_d.erase_addr = wp_inc[ADDR_W-1:0];
						end
					end
				end
				PH_CHK: begin
					if (sum_chk == '0) begin
						if (!slot_ok) begin
							result_d.reply_code = REPLY_ERROR;
						end else begin
							tbl_we = accept;
							if (!slot_in_use) begin
								used_d = used_q + SLOT_W'(1);
							end
							if (new_free > free_ptr_q) begin
								free_ptr_d = new_free;
							end
							result_d.reply_code = REPLY_ACK;
							result_d.commit_en  = 1'b1;
						end
						phase_d = PH_IDLE;
					end else begin
						// nack: rewind to the base and expect the data again
						result_d.reply_code = REPLY_NACK;
						sum_d               = '0;
						count_d             = '0;
						wp_d                = {1'b0, base_q};
						if (base_aligned_q) begin
							result_d.erase_en   = 1'b1;
							result_d.erase_addr = base_q;
						end
						phase_d = (length_q == '0) ? PH_CHK : PH_DATA;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		result_d.file_count     = used_d;
		result_d.next_free_addr = free_ptr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			region_start_q <= '0;
			region_end_q   <= '1;
			free_ptr_q     <= '0;
			used_q         <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else begin
			if (accept) begin
				phase_q        <= phase_d;
				free_ptr_q     <= free_ptr_d;
				used_q         <= used_d;
				result_valid_q <= 1'b1;
				if (tbl_we) begin
					slot_valid_q[tbl_idx] <= 1'b1;
				end
			end else begin
				if (result_ready) begin
					result_valid_q <= 1'b0;
				end
				if (cfg_valid && cfg_index == CFG_REGION_START && used_q == '0) begin
					free_ptr_q <= {1'b0, cfg_data};
				end
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_REGION_START: region_start_q <= cfg_data;
					CFG_REGION_END:   region_end_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q       <= result_d;
			length_q       <= length_d;
			count_q        <= count_d;
			sum_q          <= sum_d;
			base_q         <= base_d;
			base_aligned_q <= base_aligned_d;
			wp_q           <= wp_d;
			pslot_q        <= pslot_d;
			pkind_q        <= pkind_d;
		end
	end

endmodule

`default_nettype wire

[tb/upload_checker.sv]
`timescale 1ns / 1ps
// Checker for the file upload receiver. It follows the region registers and the upload state,
// predicts one result per item and compares the results in order.
// Depends on fur_pkg.

module upload_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_ready,
	input  fur_pkg::item_t                item,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  fur_pkg::result_t              result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [fur_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fur_pkg::ADDR_W-1:0]    cfg_data,
	output int                            fail_count,
	output int                            outstanding
);

	import fur_pkg::*;

	localparam int NSLOTS = SLOTS_DEF;
	localparam int SEG    = SEGMENT_BYTES_DEF;

	logic [ADDR_W-1:0] region_lo;
	logic [ADDR_W-1:0] region_hi;
	phase_t            stage;
	logic [15:0]       expect_len;
	logic [15:0]       got_count;
	logic [7:0]        sum;
	logic [ADDR_W-1:0] base;
	logic [PTR_W-1:0]  wr_ptr;
	logic [PTR_W-1:0]  free_ptr;
	logic [SLOT_W-1:0] slot_sel;
	logic              kind_sel;
	logic [SLOT_W-1:0] slots_used;
	slot_entry_t       slot_dir [NSLOTS];
	result_t           pending_replies [$];
	int                mismatches;

	function automatic bit seg_aligned(input logic [PTR_W-1:0] a);
		return (a % SEG) == 0;
	endfunction

	// one item through the upload sequencer; returns the result it causes
	function automatic result_t step_receiver(input item_t it);
		result_t          r;
		logic [PTR_W-1:0] nf;
		logic [7:0]       total;
		r = '0;
		if (it.op == OP_START) begin
			slot_sel = it.slot_number;
			kind_sel = it.file_kind;
			stage = PH_LEN_LO;
		end else begin
			case (stage)
				PH_LEN_LO: begin
					sum = '0;
					got_count = '0;
					expect_len = {8'h00, it.rx_byte};
					stage = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					expect_len[15:8] = it.rx_byte;
					if (free_ptr < region_lo || free_ptr > region_hi) begin
						r.reply_code = REPLY_ERROR;
						stage = PH_IDLE;
					end else begin
						base = free_ptr[ADDR_W-1:0];
						wr_ptr = free_ptr;
						if (seg_aligned(wr_ptr)) begin
							r.erase_en = 1'b1;
							r.erase_addr = wr_ptr[ADDR_W-1:0];
						end
						stage = (expect_len == 0) ? PH_CHK : PH_DATA;
					end
				end
				PH_DATA: begin
					if (wr_ptr > region_hi) begin
						r.reply_code = REPLY_ERROR;
						stage = PH_IDLE;
					end else begin
						r.write_en = 1'b1;
						r.write_addr = wr_ptr[ADDR_W-1:0];
						r.write_data = it.rx_byte;
						wr_ptr = wr_ptr + 1'b1;
						got_count = got_count + 1'b1;
						sum = sum + it.rx_byte;
						if (got_count == expect_len) begin
							stage = PH_CHK;
						end else if (seg_aligned(wr_ptr) && wr_ptr <= region_hi) begin
							r.erase_en = 1'b1;
							r.erase_addr = wr_ptr[ADDR_W-1:0];
						end
					end
				end
				PH_CHK: begin
					total = sum + it.rx_byte;
					if (total == 8'h00) begin
						if (slot_sel == 0 || slot_sel > NSLOTS) begin
							r.reply_code = REPLY_ERROR;
						end else begin
							nf = {1'b0, base} + {1'b0, got_count};
							if (!slot_dir[slot_sel - 1].in_use)
								slots_used = slots_used + 1'b1;
							slot_dir[slot_sel - 1].in_use = 1'b1;
							slot_dir[slot_sel - 1].kind = kind_sel;
							slot_dir[slot_sel - 1].start = base;
							slot_dir[slot_sel - 1].size = got_count;
							if (nf > free_ptr)
								free_ptr = nf;
							r.reply_code = REPLY_ACK;
							r.commit_en = 1'b1;
						end
						stage = PH_IDLE;
					end else begin
						// bad checksum: rewind and take the data again
						r.reply_code = REPLY_NACK;
						sum = '0;
						got_count = '0;
						wr_ptr = {1'b0, base};
						if (seg_aligned(wr_ptr)) begin
							r.erase_en = 1'b1;
							r.erase_addr = wr_ptr[ADDR_W-1:0];
						end
						stage = (expect_len == 0) ? PH_CHK : PH_DATA;
					end
				end
				default: ;
			endcase
		end
		r.file_count = slots_used;
		r.next_free_addr = free_ptr;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [PTR_W-1:0] want,
			input logic [PTR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		result_t want;
		if (!arst_n) begin
			region_lo = '0;
			region_hi = '1;
			stage = PH_IDLE;
			expect_len = '0;
			got_count = '0;
			sum = '0;
			base = '0;
			wr_ptr = '0;
			slot_sel = '0;
			kind_sel = 1'b0;
			free_ptr = '0;
			slots_used = '0;
			for (int i = 0; i < NSLOTS; i++)
				slot_dir[i] = '0;
			pending_replies.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// results first: a result never belongs to the item taken at the same edge
			if (result_valid && result_ready) begin
				if (pending_replies.size() == 0) begin
					$error("result item with no item outstanding");
					mismatches++;
				end else begin
					want = pending_replies.pop_front();
					check_field("reply_code", want.reply_code, result.reply_code);
					check_field("write_en", want.write_en, result.write_en);
					check_field("write_addr", want.write_addr, result.write_addr);
					check_field("write_data", want.write_data, result.write_data);
					check_field("erase_en", want.erase_en, result.erase_en);
					check_field("erase_addr", want.erase_addr, result.erase_addr);
					check_field("commit_en", want.commit_en, result.commit_en);
					check_field("file_count", want.file_count, result.file_count);
					check_field("next_free_addr", want.next_free_addr, result.next_free_addr);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REGION_START) begin
					region_lo = cfg_data;
					if (slots_used == 0)
						free_ptr = {1'b0, cfg_data};
				end else begin
					region_hi = cfg_data;
				end
			end
			if (item_valid && item_ready)
				pending_replies.push_back(step_receiver(item));
			fail_count <= mismatches;
			outstanding <= pending_replies.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the file upload receiver bench: clock, reset, item and register stimulus, verdict.
// Depends on fur_pkg, file_upload_receiver and upload_checker.

module testbench;
	import fur_pkg::*;

	localparam int LONG_STALL = 200;  // receiver hold-off, in cycles

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_REGION_START;
	logic [ADDR_W-1:0]    cfg_data     = '0;
	int                   fail_count;
	int                   outstanding;

	// stimulus controls
	bit                   calm         = 1'b0;  // no idling on either side while set
	bit                   stall_flip   = 1'b0;  // toggled to ask for one long hold-off
	int                   sent_items   = 0;     // items counted toward the traffic budget
	logic [PTR_W-1:0]     seen_free    = '0;    // last next-free address seen on a result

	file_upload_receiver u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	upload_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random back-pressure, none while calm. A toggle of stall_flip makes
	// this process hold ready low through the LONG_STALL hold-off while the sender keeps going,
	// so the output register fills and the block drops item_ready.
	initial begin : result_sink
		bit stall_seen;
		stall_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_flip != stall_seen) begin
				stall_seen = stall_flip;
				result_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end else begin
				result_ready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
			end
		end
	end

	// stimulus uses this to aim region_end just past the current free address
	always @(posedge clk)
		if (result_valid && result_ready)
			seen_free <= result.next_free_addr;

	// Offer one item and return at the edge where it is taken. Valid stays high on
	// return; the caller either offers the next item in the same step or drops valid.
	// Outside calm stretches, about a third of the items are preceded by idle time.
	task automatic push_item(input item_t it);
		if (!calm && $urandom_range(0, 2) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic push_start(input logic [SLOT_W-1:0] slot, input logic kind);
		item_t it;
		it.op = OP_START;
		it.rx_byte = $urandom;  // unused on a start
		it.slot_number = slot;
		it.file_kind = kind;
		sent_items++;
		push_item(it);
	endtask

	task automatic push_byte(input logic [7:0] b);
		item_t it;
		it.op = OP_BYTE;
		it.rx_byte = b;
		it.slot_number = $urandom;  // slot and kind are don't-care on a byte
		it.file_kind = $urandom;
		sent_items++;
		push_item(it);
	endtask

	// Drop valid and wait until every result is back; the block is idle after that.
	// The first edge is always taken: outstanding is a registered copy of the checker's count.
	task automatic pause_sender();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Both region registers, start first. Only called with the item channel quiet.
	task automatic set_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_REGION_START;
		cfg_data <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_REGION_END;
		cfg_data <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One upload: start, length low/high, data, checksum. A quarter of the checksums
	// are wrong (at most two in a row), so the data is sent again after a nack.
	// Some uploads are cut short; the next start then drops them.
	task automatic upload_file(input bit long_ok);
		logic [SLOT_W-1:0] slot;
		logic [7:0]        b;
		logic [7:0]        total;
		logic [7:0]        chk;
		int                len;
		int                cut;
		int                resends;
		bit                done;
		case ($urandom_range(0, 9))
			0:       slot = '0;
			1:       slot = $urandom_range(SLOTS_DEF + 1, 15);
			default: slot = $urandom_range(1, SLOTS_DEF);
		endcase
		// mostly short files, a few across a whole segment
		if (long_ok && $urandom_range(0, 24) == 0)
			len = $urandom_range(200, 520);
		else if ($urandom_range(0, 3) == 0)
			len = $urandom_range(13, 60);
		else
			len = $urandom_range(0, 12);
		cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 3) : -1;
		push_start(slot, $urandom_range(0, 1));
		if (cut == 0)
			return;
		push_byte(len[7:0]);
		if (cut == 1)
			return;
		push_byte(len[15:8]);
		if (cut == 2)
			return;
		resends = 0;
		done = 1'b0;
		while (!done) begin
			total = '0;
			for (int k = 0; k < len; k++) begin
				b = $urandom;
				push_byte(b);
				total += b;
				if (cut == 3 && k == len / 2)
					return;
			end
			if (resends < 2 && $urandom_range(0, 3) == 0) begin
				chk = 8'h00 - total + $urandom_range(1, 255);
				resends++;
			end else begin
				chk = 8'h00 - total;
				done = 1'b1;
			end
			push_byte(chk);
		end
	endtask

	// fully random items; not counted toward the budget
	task automatic send_noise();
		item_t it;
		repeat ($urandom_range(1, 4)) begin
			it.op = $urandom;
			it.rx_byte = $urandom;
			it.slot_number = $urandom;
			it.file_kind = $urandom;
			push_item(it);
		end
	endtask

	task automatic run_traffic(input int budget, input bit long_ok);
		int stop_at;
		stop_at = sent_items + budget;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				send_noise();
			else
				upload_file(long_ok);
		end
	endtask

	initial begin : stimulus
		logic [ADDR_W-1:0] lo_now;
		logic [PTR_W-1:0]  reach;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// reset settings, nothing committed yet
		push_byte(8'hFF);                   // no upload armed: ignored
		push_start(4'd0, 1'b1);             // slot 0 is not a valid slot
		push_byte(8'h00);
		push_byte(8'h00);                   // zero length, erase at address 0
		push_byte(8'h00);                   // checksum good, slot bad: error
		pause_sender();

		// no slot in use, so the free address follows region_start to 0xFFFC
		set_region(16'hFFFC, 16'hFFFF);
		push_start(4'd15, 1'b0);
		push_byte(8'h14);
		push_byte(8'h00);                   // 20 bytes announced, only 4 fit
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'hAA);
		push_byte(8'h55);                   // lands on 0xFFFF; no erase past the end
		push_byte(8'h01);                   // beyond region end: error
		pause_sender();

		set_region(16'h0000, 16'hFFFF);
		push_start(4'd15, 1'b0);
		push_start(4'd1, 1'b1);             // restart while armed
		push_byte(8'h02);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h01);
		push_byte(8'h01);                   // sum 0x01: nack, rewind, erase 0 again
		push_byte(8'hFF);
		push_byte(8'h01);
		push_byte(8'h00);                   // ack, slot 1 committed

		// --- random, full region ---
		calm <= 1'b1;                       // stretch with no idling at all
		run_traffic(60, 1'b0);
		calm <= 1'b0;
		run_traffic(50, 1'b1);
		stall_flip <= ~stall_flip;          // long receiver hold-off, sender keeps pushing
		run_traffic(40, 1'b0);
		pause_sender();                     // sender waits for every result
		run_traffic(100, 1'b1);

		// --- region end just above the free address: writes run off the end ---
		for (int n = 0; n < 4; n++) begin
			pause_sender();
			if (n == 3)
				reach = seen_free - 1'b1;   // free address already outside
			else
				reach = seen_free + $urandom_range(0, 40);
			set_region(16'h0000, (reach > 17'h0FFFF) ? 16'hFFFF : reach[ADDR_W-1:0]);
			repeat (2) upload_file(1'b0);
		end

		// --- register extremes: empty region, every upload errors at length high ---
		pause_sender();
		set_region(16'hFFFF, 16'h0000);
		run_traffic(20, 1'b0);

		// --- region start moved, no longer followed by the free address ---
		pause_sender();
		lo_now = $urandom_range(0, (seen_free > 17'h0FFFF) ? 65535 : seen_free);
		set_region(lo_now, 16'hFFFF);
		run_traffic(140, 1'b1);

		// drain, then wait out anything stray before the verdict
		pause_sender();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule

[file_upload_receiver.f]
rtl/fur_pkg.sv
rtl/fur_ram.sv
rtl/file_upload_receiver.sv
tb/upload_checker.sv
tb/testbench.sv
